### sv/der_tag_length_header_encoder_top_assert.svh
// Assertion macros for the DER header encoder top level.
`ifndef DER_TAG_LENGTH_HEADER_ENCODER_TOP_ASSERT_SVH
`define DER_TAG_LENGTH_HEADER_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define DER_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define DER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/der_hdr_pkg.sv
// Shared types and constants of the DER header encoder.
`timescale 1ns / 1ps
package der_hdr_pkg;

	localparam int TAG_DIGIT_W = 7;
	localparam int TAG_DIGITS  = 5;
	localparam int LEN_DIGIT_W = 8;
	localparam int LEN_DIGITS  = 8;
	localparam int LEN_CNT_W   = 4;

	localparam logic [4:0]  HIGH_TAG_MARK   = 5'h1F;
	localparam logic [31:0] HIGH_TAG_FIRST  = 32'd31;
	localparam logic [63:0] SHORT_LEN_MAX   = 64'd127;
	localparam logic [7:0]  INDEF_LEN_OCTET = 8'h80;
	localparam logic [7:0]  EOC_OCTET       = 8'h00;

	typedef struct packed {
		logic        kind;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [31:0] tag_number;
		logic        length_mode;
		logic [63:0] value_length;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} res_t;

	typedef struct packed {
		logic load;
		logic skip;
		logic shift;
	} ser_ctl_t;

	typedef struct packed {
		logic settled;
		logic one_left;
	} ser_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EOC0,
		ST_EOC1,
		ST_SKIP,
		ST_ID,
		ST_TAG,
		ST_LHDR,
		ST_LEN
	} state_t;

endpackage

### sv/der_tag_length_header_encoder_top.sv
// Top level of the ASN.1 DER identifier and length octet encoder.
//
// A request is presented on cmd and taken at a rising edge where start is high and
// busy is low. A header request yields the identifier octets and then the length
// octets; an end-of-contents request yields two zero octets. Each octet appears on
// res for exactly one cycle with res_valid high, and res.last marks the final octet.
// The receiver cannot stall, so octets leave at one per cycle once emission begins.
// After a header request is taken, the block sits in a skip state dropping leading
// zero digits of the tag number and of the length, both shift registers in parallel,
// until each has a nonzero top digit or one digit left. Then it emits one octet per
// cycle, up to fifteen, and the first octet reaches res in the cycle after it is
// formed. Busy stays high through the skip state and all header octets; an
// end-of-contents request keeps busy high while its two octets are formed. A new request may be taken
// in the cycle after the final octet is formed, while that octet is still on res.
// Reset returns the controller to idle and clears res_valid; no octets are pending.
`timescale 1ns / 1ps
`include "der_tag_length_header_encoder_top_assert.svh"
module der_tag_length_header_encoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  der_hdr_pkg::cmd_t cmd,
	output logic              busy,
	output logic              res_valid,
	output der_hdr_pkg::res_t res
);
	import der_hdr_pkg::*;

	localparam int TAG_BITS = TAG_DIGIT_W * TAG_DIGITS;
	localparam int LEN_BITS = LEN_DIGIT_W * LEN_DIGITS;

	state_t     state_q, state_d;
	logic [2:0] lead_q;
	logic       small_q, short_q, indef_q;
	logic [4:0] tag5_q;
	logic [6:0] len7_q;
	res_t       res_q, res_d;
	logic       res_valid_q, emit;
	logic       accept;

	ser_ctl_t                   tag_ctl, len_ctl;
	ser_sts_t                   tag_sts, len_sts;
	logic [TAG_DIGIT_W-1:0]     tag_digit;
	logic [LEN_DIGIT_W-1:0]     len_digit;
	logic [LEN_CNT_W-1:0]       len_cnt;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	der_hdr_digit_ser #(
		.DIGIT_W (TAG_DIGIT_W),
		.N_DIGITS(TAG_DIGITS)
	) u_tag_ser (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (tag_ctl),
		.value (TAG_BITS'(cmd.tag_number)),
		.digit (tag_digit),
		.count (),
		.sts   (tag_sts)
	);

	der_hdr_digit_ser #(
		.DIGIT_W (LEN_DIGIT_W),
		.N_DIGITS(LEN_DIGITS)
	) u_len_ser (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (len_ctl),
		.value (LEN_BITS'(cmd.value_length)),
		.digit (len_digit),
		.count (len_cnt),
		.sts   (len_sts)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = cmd.kind ? ST_EOC0 : ST_SKIP;
				end
			end
			ST_EOC0: state_d = ST_EOC1;
			ST_EOC1: state_d = ST_IDLE;
			ST_SKIP: begin
				if (tag_sts.settled && len_sts.settled) begin
					state_d = ST_ID;
				end
			end
			ST_ID:   state_d = small_q ? ST_LHDR : ST_TAG;
			ST_TAG: begin
				if (tag_sts.one_left) begin
					state_d = ST_LHDR;
				end
			end
			ST_LHDR: state_d = (indef_q || short_q) ? ST_IDLE : ST_LEN;
			ST_LEN: begin
				if (len_sts.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit          = 1'b0;
		res_d         = '0;
		tag_ctl       = '0;
		len_ctl       = '0;
		tag_ctl.load  = accept;
		len_ctl.load  = accept;
		unique case (state_q)
			ST_IDLE: ;
			ST_EOC0: begin
				emit           = 1'b1;
				res_d.out_byte = EOC_OCTET;
			end
			ST_EOC1: begin
				emit           = 1'b1;
				res_d.out_byte = EOC_OCTET;
				res_d.last     = 1'b1;
			end
			ST_SKIP: begin
				tag_ctl.skip = 1'b1;
				len_ctl.skip = 1'b1;
			end
			ST_ID: begin
				emit           = 1'b1;
				res_d.out_byte = {lead_q, small_q ? tag5_q : HIGH_TAG_MARK};
			end
			ST_TAG: begin
				emit           = 1'b1;
				res_d.out_byte = {!tag_sts.one_left, tag_digit};
				tag_ctl.shift  = 1'b1;
			end
			ST_LHDR: begin
				emit       = 1'b1;
				res_d.last = indef_q || short_q;
				if (indef_q) begin
					res_d.out_byte = INDEF_LEN_OCTET;
				end else if (short_q) begin
					res_d.out_byte = {1'b0, len7_q};
				end else begin
					res_d.out_byte = INDEF_LEN_OCTET | 8'(len_cnt);
				end
			end
			ST_LEN: begin
				emit           = 1'b1;
				res_d.out_byte = len_digit;
				res_d.last     = len_sts.one_left;
				len_ctl.shift  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		if (accept) begin
			lead_q  <= {cmd.tag_class, cmd.constructed};
			small_q <= (cmd.tag_number < HIGH_TAG_FIRST);
			short_q <= (cmd.value_length <= SHORT_LEN_MAX);
			indef_q <= cmd.length_mode;
			tag5_q  <= cmd.tag_number[4:0];
			len7_q  <= cmd.value_length[6:0];
		end
	end

	`DER_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
	`DER_ASSERT_NEXT(a_last_gap, res_valid && res.last, !res_valid, "octet followed last octet")
	`DER_ASSERT_SAME(a_mid_busy, res_valid && !res.last, busy, "idle while a request is open")

endmodule

### sv/der_hdr_digit_ser.sv
// Digit shift register that drops leading zero digits and emits the rest, top digit first.
`timescale 1ns / 1ps
module der_hdr_digit_ser #(
	parameter int DIGIT_W  = 8,
	parameter int N_DIGITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  der_hdr_pkg::ser_ctl_t                  ctl,
	input  logic [DIGIT_W*N_DIGITS-1:0]            value,
	output logic [DIGIT_W-1:0]                     digit,
	output logic [$clog2(N_DIGITS+1)-1:0]          count,
	output der_hdr_pkg::ser_sts_t                  sts
);
	import der_hdr_pkg::*;

	localparam int TOTAL = DIGIT_W * N_DIGITS;
	localparam int CNT_W = $clog2(N_DIGITS + 1);

	logic [TOTAL-1:0] sreg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             top_zero;

	assign digit        = sreg_q[TOTAL-1 -: DIGIT_W];
	assign count        = cnt_q;
	assign top_zero     = (digit == '0);
	assign sts.one_left = (cnt_q == CNT_W'(1));
	assign sts.settled  = !top_zero || sts.one_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(N_DIGITS);
		end else if (ctl.load) begin
			cnt_q <= CNT_W'(N_DIGITS);
		end else if (ctl.shift || (ctl.skip && !sts.settled)) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sreg_q <= value;
		end else if (ctl.shift || (ctl.skip && !sts.settled)) begin
			sreg_q <= {sreg_q[TOTAL-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

endmodule

### test/der_hdr_test_pkg.sv
// Request codes shared by the DER header encoder checker and its testbench.
`timescale 1ns / 1ps
package der_hdr_test_pkg;

	localparam logic KIND_HEADER    = 1'b0;
	localparam logic KIND_EOC       = 1'b1;
	localparam logic LEN_DEFINITE   = 1'b0;
	localparam logic LEN_INDEFINITE = 1'b1;

endpackage

### test/der_tag_length_header_encoder_checker.sv
// Checker that predicts and compares the octets of the DER header encoder.
`timescale 1ns / 1ps
module der_tag_length_header_encoder_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  der_hdr_pkg::cmd_t cmd,
	input  logic              res_valid,
	input  der_hdr_pkg::res_t res,
	output int                failures,
	output int                outstanding,
	output int                octets_seen
);
	import der_hdr_pkg::*;
	import der_hdr_test_pkg::*;

	localparam logic [7:0] CONT_BIT = 8'h80;

	res_t expected_octets[$];

	assign outstanding = expected_octets.size();

	task automatic report_mismatch(input string msg);
		if (failures < 50) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		failures++;
	endtask

	function automatic void encode_request(input cmd_t c);
		logic [7:0] octs[$];
		logic [7:0] lead;
		int ngroups;
		int nbytes;
		lead = {c.tag_class, c.constructed, 5'b0};
		if (c.kind == KIND_EOC) begin
			octs.insert(octs.size(), EOC_OCTET);
			octs.insert(octs.size(), EOC_OCTET);
		end else begin
			if (c.tag_number < HIGH_TAG_FIRST) begin
				octs.insert(octs.size(), lead | 8'(c.tag_number));
			end else begin
				ngroups = 1;
				while (ngroups < TAG_DIGITS &&
					(c.tag_number >> (TAG_DIGIT_W * ngroups)) != 0) begin
					ngroups++;
				end
				octs.insert(octs.size(), lead | {3'b0, HIGH_TAG_MARK});
				for (int i = ngroups - 1; i >= 1; i--) begin
					octs.insert(octs.size(), CONT_BIT |
						{1'b0, 7'(c.tag_number >> (TAG_DIGIT_W * i))});
				end
				octs.insert(octs.size(), {1'b0, c.tag_number[6:0]});
			end
			if (c.length_mode == LEN_INDEFINITE) begin
				octs.insert(octs.size(), INDEF_LEN_OCTET);
			end else if (c.value_length <= SHORT_LEN_MAX) begin
				octs.insert(octs.size(), c.value_length[7:0]);
			end else begin
				nbytes = 1;
				while (nbytes < LEN_DIGITS &&
					(c.value_length >> (LEN_DIGIT_W * nbytes)) != 0) begin
					nbytes++;
				end
				octs.insert(octs.size(), CONT_BIT | 8'(nbytes));
				for (int i = nbytes - 1; i >= 0; i--) begin
					octs.insert(octs.size(), 8'(c.value_length >> (LEN_DIGIT_W * i)));
				end
			end
		end
		foreach (octs[i]) begin
			expected_octets.insert(expected_octets.size(),
				res_t'{octs[i], i == octs.size() - 1});
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			expected_octets.delete();
		end else begin
			if (res_valid) begin
				octets_seen++;
				if (expected_octets.size() == 0) begin
					report_mismatch($sformatf("unexpected octet %02h last=%0b",
						res.out_byte, res.last));
				end else begin
					want = expected_octets.pop_front();
					if (res.out_byte !== want.out_byte) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							res.out_byte, want.out_byte));
					end
					if (res.last !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b on octet %02h",
							res.last, want.last, want.out_byte));
					end
				end
			end
			if (start && !busy) begin
				encode_request(cmd);
			end
		end
	end

endmodule

### test/der_tag_length_header_encoder_top_test.sv
// Testbench top for the DER header encoder: stimulus, reset and verdict.
`timescale 1ns / 1ps
module der_tag_length_header_encoder_top_test;
	import der_hdr_pkg::*;
	import der_hdr_test_pkg::*;

	localparam int RANDOM_ITEMS = 290;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic res_valid;
	res_t res;
	int   failures;
	int   outstanding;
	int   octets_seen;
	int   sent;
	int   eoc_sent;
	int   high_tags;
	cmd_t directed[$];

	der_tag_length_header_encoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

	der_tag_length_header_encoder_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res         (res),
		.failures    (failures),
		.outstanding (outstanding),
		.octets_seen (octets_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic cmd_t make_cmd(input logic kind, input logic [1:0] cls,
		input logic cons, input logic [31:0] tag, input logic mode,
		input logic [63:0] len);
		cmd_t c;
		c.kind = kind;
		c.tag_class = cls;
		c.constructed = cons;
		c.tag_number = tag;
		c.length_mode = mode;
		c.value_length = len;
		return c;
	endfunction

	function automatic void add_directed(input cmd_t c);
		directed.insert(directed.size(), c);
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.kind = ($urandom_range(0, 9) == 0) ? KIND_EOC : KIND_HEADER;
		c.tag_class = 2'($urandom_range(0, 3));
		c.constructed = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: c.tag_number = $urandom_range(0, 30);
			1: c.tag_number = $urandom_range(31, 300);
			default: c.tag_number = $urandom >> $urandom_range(0, 31);
		endcase
		c.length_mode = ($urandom_range(0, 4) == 0) ? LEN_INDEFINITE : LEN_DEFINITE;
		case ($urandom_range(0, 3))
			0: c.value_length = 64'($urandom_range(0, 127));
			1: c.value_length = 64'($urandom_range(128, 70000));
			default: c.value_length = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
		return c;
	endfunction

	function automatic int pick_gap(input int idx);
		int roll;
		roll = $urandom_range(0, 99);
		if ((idx % 60) < 15) begin
			return 0;
		end
		if (roll < 40) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// Holds start high from one transaction to the next when no gap is chosen.
	task automatic issue_request(input cmd_t c, input int idx);
		int gap;
		gap = pick_gap(idx);
		if (gap > 0) begin
			start <= 1'b0;
			cmd <= random_cmd();
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sent++;
		if (c.kind == KIND_EOC) eoc_sent++;
		else if (c.tag_number >= HIGH_TAG_FIRST) high_tags++;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		sent = 0;
		eoc_sent = 0;
		high_tags = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_directed(make_cmd(KIND_EOC, 2'd3, 1'b1, '1, LEN_INDEFINITE, '1));
		add_directed(make_cmd(KIND_EOC, 2'd0, 1'b0, '0, LEN_DEFINITE, '0));
		add_directed(make_cmd(KIND_HEADER, 2'd0, 1'b0, 32'd0, LEN_DEFINITE, 64'd0));
		add_directed(make_cmd(KIND_HEADER, 2'd1, 1'b1, 32'd30, LEN_DEFINITE, 64'd127));
		add_directed(make_cmd(KIND_HEADER, 2'd2, 1'b0, 32'd31, LEN_DEFINITE, 64'd128));
		add_directed(make_cmd(KIND_HEADER, 2'd3, 1'b1, 32'd127, LEN_DEFINITE, 64'd255));
		add_directed(make_cmd(KIND_HEADER, 2'd0, 1'b1, 32'd128, LEN_DEFINITE, 64'd256));
		add_directed(make_cmd(KIND_HEADER, 2'd1, 1'b0, 32'd16383, LEN_DEFINITE,
			64'hFFFF));
		add_directed(make_cmd(KIND_HEADER, 2'd2, 1'b1, 32'd16384, LEN_DEFINITE,
			64'h1_0000));
		add_directed(make_cmd(KIND_HEADER, 2'd3, 1'b0, 32'h0FFF_FFFF, LEN_DEFINITE,
			64'h1_0000_0000));
		add_directed(make_cmd(KIND_HEADER, 2'd3, 1'b1, 32'h1000_0000, LEN_DEFINITE,
			64'h0100_0000_0000_0000));
		add_directed(make_cmd(KIND_HEADER, 2'd3, 1'b1, 32'hFFFF_FFFF, LEN_DEFINITE,
			64'hFFFF_FFFF_FFFF_FFFF));
		add_directed(make_cmd(KIND_HEADER, 2'd0, 1'b0, 32'hFFFF_FFFF, LEN_INDEFINITE,
			64'hFFFF_FFFF_FFFF_FFFF));
		add_directed(make_cmd(KIND_HEADER, 2'd1, 1'b1, 32'd5, LEN_INDEFINITE, 64'd0));
		add_directed(make_cmd(KIND_HEADER, 2'd2, 1'b1, 32'd31, LEN_INDEFINITE,
			64'd300));
		add_directed(make_cmd(KIND_HEADER, 2'd0, 1'b1, 32'd16, LEN_DEFINITE, 64'd1));
		add_directed(make_cmd(KIND_HEADER, 2'd2, 1'b0, 32'd1, LEN_DEFINITE,
			64'h8000_0000_0000_0000));
		add_directed(make_cmd(KIND_HEADER, 2'd1, 1'b0, 32'h8000_0000, LEN_DEFINITE,
			64'd200));

		foreach (directed[i]) issue_request(directed[i], i);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			issue_request(random_cmd(), i);
		end
		start <= 1'b0;

		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (32) @(posedge clk);

		$display("Issued %0d requests: %0d end-of-contents, %0d in high-tag form.",
			sent, eoc_sent, high_tags);
		$display("Compared %0d octets against the prediction, %0d mismatches.",
			octets_seen, failures);
		if (failures == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/der_hdr_pkg.sv
sv/der_hdr_digit_ser.sv
sv/der_tag_length_header_encoder_top.sv
test/der_hdr_test_pkg.sv
test/der_tag_length_header_encoder_checker.sv
test/der_tag_length_header_encoder_top_test.sv
